// ===== rtl/core/srosub_pkg.sv =====
// ----------------------------------------------------------------------------
// srosub_pkg
// Shared types and codes of the scroll region occlusion subtractor.
// ----------------------------------------------------------------------------
package srosub_pkg;

    localparam int FIELD_W = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register index of the scroll distance.
    localparam logic REG_SCROLL_DIST = 1'b0;

    // Request codes.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_SUB   = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_OVF     = 2'd1;
    localparam logic [1:0] KIND_COPY    = 2'd2;
    localparam logic [1:0] KIND_REPAINT = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FIELD_W-1:0] rect_x;
        logic [FIELD_W-1:0] rect_y;
        logic [FIELD_W-1:0] rect_width;
        logic [FIELD_W-1:0] rect_height;
    } t_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [FIELD_W-1:0] out_x;
        logic [FIELD_W-1:0] out_y;
        logic [FIELD_W-1:0] out_width;
        logic [FIELD_W-1:0] out_height;
        logic               last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCHK,
        ST_S_RD,
        ST_S_CLIP,
        ST_S_SPLIT,
        ST_S_PUT,
        ST_D_RD,
        ST_D_CHK,
        ST_D_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_seed;
        logic shift;
        logic read;
        logic clip;
        logic split;
        logic put;
        logic next_idx;
        logic commit;
        logic overflow;
        logic drain_chk;
        logic emit_ack;
        logic emit_ovf;
        logic emit_final;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       occ_empty;
        logic       list_empty;
        logic       idx_last;
        logic       mask_empty;
        logic       list_full;
    } t_stat;

endpackage

// ===== rtl/core/srosub_ctrl.sv =====
// ----------------------------------------------------------------------------
// srosub_ctrl
// Sequencer that steps the datapath through start, subtract and drain.
// ----------------------------------------------------------------------------
module srosub_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  srosub_pkg::t_stat i_stat,
    output srosub_pkg::t_cmd  o_cmd,
    output logic             o_busy
);
    import srosub_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.req_type)
                    REQ_START: begin
                        o_cmd.start_seed = 1'b1;
                        o_cmd.emit_ack   = 1'b1;
                        n_state          = ST_IDLE;
                    end
                    REQ_SUB: begin
                        o_cmd.shift = 1'b1;
                        n_state     = ST_SCHK;
                    end
                    REQ_DRAIN: begin
                        n_state = i_stat.list_empty ? ST_D_FIN : ST_D_RD;
                    end
                    default: begin
                        o_cmd.emit_ack = 1'b1;
                        n_state        = ST_IDLE;
                    end
                endcase
            end
            ST_SCHK: begin
                if (i_stat.occ_empty || i_stat.list_empty) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_S_RD;
                end
            end
            ST_S_RD: begin
                o_cmd.read = 1'b1;
                n_state    = ST_S_CLIP;
            end
            ST_S_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = ST_S_SPLIT;
            end
            ST_S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = ST_S_PUT;
            end
            ST_S_PUT: begin
                if (i_stat.mask_empty) begin
                    o_cmd.next_idx = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.commit   = 1'b1;
                        o_cmd.emit_ack = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_S_RD;
                    end
                end else if (i_stat.list_full) begin
                    o_cmd.overflow = 1'b1;
                    o_cmd.emit_ovf = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.put = 1'b1;
                end
            end
            ST_D_RD: begin
                o_cmd.read = 1'b1;
                n_state    = ST_D_CHK;
            end
            ST_D_CHK: begin
                o_cmd.drain_chk = 1'b1;
                o_cmd.next_idx  = 1'b1;
                n_state         = i_stat.idx_last ? ST_D_FIN : ST_D_RD;
            end
            ST_D_FIN: begin
                o_cmd.emit_final = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/srosub_dp.sv =====
// ----------------------------------------------------------------------------
// srosub_dp
// Rectangle arithmetic, region store and result register.
// ----------------------------------------------------------------------------
module srosub_dp #(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  srosub_pkg::t_cmd                      i_cmd,
    input  srosub_pkg::t_req                      i_req,
    input  logic [srosub_pkg::FIELD_W-1:0]        i_scroll_dist,
    output srosub_pkg::t_stat                     o_stat,
    output logic                                  o_valid,
    output srosub_pkg::t_result                   o_result
);
    import srosub_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int E     = COORD_BITS + 1;
    localparam int MW    = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int IW    = $clog2(MAX_REGIONS);
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;

    typedef struct packed {
        logic [C-1:0] x;
        logic [C-1:0] y;
        logic [C-1:0] w;
        logic [C-1:0] h;
    } t_box;

    function automatic logic is_empty(t_box b);
        return (b.w == '0) || (b.h == '0);
    endfunction

    function automatic logic [C-1:0] from_field(logic [FIELD_W-1:0] v);
        logic [MW-1:0] t;
        t = MW'(v);
        return t[C-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(logic [C-1:0] v);
        logic [MW-1:0] t;
        t = MW'(v);
        return t[FIELD_W-1:0];
    endfunction

    function automatic t_box box_clip(t_box a, t_box b);
        logic [C-1:0] l;
        logic [C-1:0] t;
        logic [E-1:0] r;
        logic [E-1:0] bt;
        logic [E-1:0] ar;
        logic [E-1:0] br;
        logic [E-1:0] ab;
        logic [E-1:0] bb;
        t_box         z;
        z  = '0;
        l  = (a.x > b.x) ? a.x : b.x;
        t  = (a.y > b.y) ? a.y : b.y;
        ar = E'(a.x) + E'(a.w);
        br = E'(b.x) + E'(b.w);
        ab = E'(a.y) + E'(a.h);
        bb = E'(b.y) + E'(b.h);
        r  = (ar < br) ? ar : br;
        bt = (ab < bb) ? ab : bb;
        if (!is_empty(a) && !is_empty(b) && (r > E'(l)) && (bt > E'(t))) begin
            z.x = l;
            z.y = t;
            z.w = C'(r - E'(l));
            z.h = C'(bt - E'(t));
        end
        return z;
    endfunction

    function automatic t_box box_union(t_box a, t_box b);
        logic [E-1:0] ar;
        logic [E-1:0] br;
        logic [E-1:0] ab;
        logic [E-1:0] bb;
        logic [E-1:0] r;
        logic [E-1:0] bt;
        t_box         z;
        ar = E'(a.x) + E'(a.w);
        br = E'(b.x) + E'(b.w);
        ab = E'(a.y) + E'(a.h);
        bb = E'(b.y) + E'(b.h);
        r  = (ar > br) ? ar : br;
        bt = (ab > bb) ? ab : bb;
        z.x = (a.x < b.x) ? a.x : b.x;
        z.y = (a.y < b.y) ? a.y : b.y;
        z.w = C'(r - E'(z.x));
        z.h = C'(bt - E'(z.y));
        if (is_empty(a)) begin
            z = b;
        end else if (is_empty(b)) begin
            z = a;
        end
        return z;
    endfunction

    t_req               r_req;
    t_box               r_occ;
    t_box               r_seed;
    t_box               r_repaint;
    t_box               r_region;
    t_box               r_ov;
    t_box               r_piece [4];
    logic [3:0]         r_mask;
    logic [IW-1:0]      r_idx;
    logic [CW-1:0]      r_nc;
    logic [CW-1:0]      r_count;
    logic               r_bank;
    t_box               r_rd;
    t_box               r_mem [DEPTH];
    logic               r_valid;
    t_result            r_res;
    t_result            n_res;

    // Request fields reduced to the coordinate space.
    t_box req_box;
    assign req_box = '{x: from_field(r_req.rect_x), y: from_field(r_req.rect_y),
                       w: from_field(r_req.rect_width), h: from_field(r_req.rect_height)};

    // Seed clipped to the coordinate space.
    t_box seed_clip;
    always_comb begin
        seed_clip = req_box;
        if ((E'(req_box.x) + E'(req_box.w)) > (E'(1) << C)) begin
            seed_clip.w = C'((E'(1) << C) - E'(req_box.x));
        end
        if ((E'(req_box.y) + E'(req_box.h)) > (E'(1) << C)) begin
            seed_clip.h = C'((E'(1) << C) - E'(req_box.y));
        end
        if (is_empty(seed_clip)) begin
            seed_clip = '0;
        end
    end

    // Occluder moved up by the scroll distance and trimmed at row zero.
    t_box          occ_shift;
    logic [MW-1:0] y_ext;
    logic [MW-1:0] d_ext;
    logic [MW-1:0] h_ext;
    logic [MW-1:0] trim;
    always_comb begin
        y_ext     = MW'(req_box.y);
        d_ext     = MW'(i_scroll_dist);
        h_ext     = MW'(req_box.h);
        trim      = d_ext - y_ext;
        occ_shift = req_box;
        if (is_empty(req_box)) begin
            occ_shift = '0;
        end else if (y_ext >= d_ext) begin
            occ_shift.y = C'(y_ext - d_ext);
        end else if (trim >= h_ext) begin
            occ_shift = '0;
        end else begin
            occ_shift.y = '0;
            occ_shift.h = C'(h_ext - trim);
        end
    end

    // Remaining pieces of a region around its overlap: above, below, left, right.
    t_box         pc [4];
    logic [3:0]   pc_ok;
    logic [E-1:0] rr;
    logic [E-1:0] rb;
    logic [E-1:0] orr;
    logic [E-1:0] ob;
    always_comb begin
        rr  = E'(r_region.x) + E'(r_region.w);
        rb  = E'(r_region.y) + E'(r_region.h);
        orr = E'(r_ov.x) + E'(r_ov.w);
        ob  = E'(r_ov.y) + E'(r_ov.h);
        pc[0] = '{x: r_region.x, y: r_region.y, w: r_region.w,
                  h: C'(r_ov.y - r_region.y)};
        pc[1] = '{x: r_region.x, y: C'(ob), w: r_region.w, h: C'(rb - ob)};
        pc[2] = '{x: r_region.x, y: r_ov.y, w: C'(r_ov.x - r_region.x), h: r_ov.h};
        pc[3] = '{x: C'(orr), y: r_ov.y, w: C'(rr - orr), h: r_ov.h};
        pc_ok = {orr < rr, r_ov.x > r_region.x, ob < rb, r_ov.y > r_region.y};
        if (is_empty(r_ov)) begin
            pc[0] = r_region;
            pc_ok = 4'b0001;
        end
    end

    // Lowest pending piece is written first.
    logic [1:0] sel;
    always_comb begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = 2'(k);
            end
        end
    end

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_box          mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = {r_bank, {IW{1'b0}}};
        mem_wd = seed_clip;
        if (i_cmd.start_seed) begin
            mem_we = !is_empty(seed_clip);
        end else if (i_cmd.put) begin
            mem_we = 1'b1;
            mem_wa = {~r_bank, r_nc[IW-1:0]};
            mem_wd = r_piece[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[{r_bank, r_idx}];
        end
    end

    logic drain_short;
    assign drain_short = (MW'(r_rd.h) <= MW'(i_scroll_dist));

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.shift) begin
            r_occ <= occ_shift;
        end
        if (i_cmd.clip) begin
            r_region <= r_rd;
            r_ov     <= box_clip(r_rd, r_occ);
        end
        if (i_cmd.split) begin
            for (int k = 0; k < 4; k++) begin
                r_piece[k] <= pc[k];
            end
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.load) begin
            r_nc <= '0;
        end else if (i_cmd.put) begin
            r_nc <= r_nc + CW'(1);
        end
        if (i_cmd.split) begin
            r_mask <= pc_ok;
        end else if (i_cmd.put) begin
            r_mask[sel] <= 1'b0;
        end
    end

    // List and box state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_bank    <= 1'b0;
            r_seed    <= '0;
            r_repaint <= '0;
        end else begin
            if (i_cmd.start_seed) begin
                r_seed    <= seed_clip;
                r_repaint <= '0;
                r_count   <= is_empty(seed_clip) ? CW'(0) : CW'(1);
            end
            if (i_cmd.split) begin
                r_repaint <= box_union(r_repaint, r_ov);
            end
            if (i_cmd.commit) begin
                r_bank  <= ~r_bank;
                r_count <= r_nc;
            end
            if (i_cmd.overflow) begin
                r_repaint <= box_union(r_repaint, r_seed);
                r_count   <= '0;
            end
            if (i_cmd.drain_chk && drain_short) begin
                r_repaint <= box_union(r_repaint, r_rd);
            end
            if (i_cmd.emit_final) begin
                r_repaint <= '0;
                r_count   <= '0;
            end
        end
    end

    // Result register: each result is valid for a single cycle.
    t_box fin_box;
    assign fin_box = is_empty(r_repaint) ? '0 : r_repaint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_ack || i_cmd.emit_ovf || i_cmd.emit_final
                       || (i_cmd.drain_chk && !drain_short);
        end
    end

    always_comb begin
        n_res = '0;
        if (i_cmd.emit_ack) begin
            n_res.result_kind = KIND_ACK;
            n_res.last        = 1'b1;
        end else if (i_cmd.emit_ovf) begin
            n_res.result_kind = KIND_OVF;
            n_res.last        = 1'b1;
        end else if (i_cmd.drain_chk) begin
            n_res.result_kind = KIND_COPY;
            n_res.out_x       = to_field(r_rd.x);
            n_res.out_y       = to_field(r_rd.y);
            n_res.out_width   = to_field(r_rd.w);
            n_res.out_height  = to_field(r_rd.h);
        end else if (i_cmd.emit_final) begin
            n_res.result_kind = KIND_REPAINT;
            n_res.out_x       = to_field(fin_box.x);
            n_res.out_y       = to_field(fin_box.y);
            n_res.out_width   = to_field(fin_box.w);
            n_res.out_height  = to_field(fin_box.h);
            n_res.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign o_stat.req_type   = r_req.req_type;
    assign o_stat.occ_empty  = is_empty(r_occ);
    assign o_stat.list_empty = (r_count == '0);
    assign o_stat.idx_last   = ((CW'(r_idx) + CW'(1)) >= r_count);
    assign o_stat.mask_empty = (r_mask == 4'b0000);
    assign o_stat.list_full  = (r_nc == CW'(MAX_REGIONS));

endmodule

// ===== rtl/core/scroll_region_occlusion_subtractor.sv =====
// ----------------------------------------------------------------------------
// scroll_region_occlusion_subtractor
// Keeps a list of scrollable regions and subtracts occluders from it.
// ----------------------------------------------------------------------------
// Usage. A request is taken on i_req at a rising edge where start is high and
// busy is low. A start request seeds the list with one rectangle, a subtract
// request removes a shifted occluder from every region, and a drain request
// emits the copy regions followed by the repaint box. Each result appears on
// o_result for exactly one cycle with o_result_valid high; the receiver cannot
// stall, so results leave as soon as they are made. The final result of every
// request carries last.
// Timing. A start or unknown request has its result set up in the decode
// state. A subtract reads each stored region from the region store, clips it,
// splits it and writes its pieces back one a cycle. A drain reads and checks
// each stored region in turn. busy falls as the last result appears, so a new
// request can be taken in that cycle; one request is worked on at a time.
// Reset. i_rst_n (synchronous, active low) empties the list and the repaint and
// seed boxes and clears the scroll distance. The region store needs no clearing
// pass: only entries below the region count are ever read.
// Configuration. The scroll distance sits at byte address 0 of the APB port and
// should be written only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module scroll_region_occlusion_subtractor #(
    parameter int MAX_REGIONS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  srosub_pkg::t_req                    i_req,
    output logic                                o_result_valid,
    output srosub_pkg::t_result                 o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srosub_pkg::APB_AW-1:0]       paddr,
    input  logic [srosub_pkg::APB_DW-1:0]       pwdata,
    output logic [srosub_pkg::APB_DW-1:0]       prdata,
    output logic                                pready
);
    import srosub_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [FIELD_W-1:0]  r_scroll_dist;
    logic                cfg_wr;

    // The register index is the word address; only index zero exists.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SCROLL_DIST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_dist <= '0;
        end else if (cfg_wr) begin
            r_scroll_dist <= pwdata[FIELD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SCROLL_DIST) ? APB_DW'(r_scroll_dist) : '0;

    // The controller sequences each request; the datapath holds every rectangle.
    srosub_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    srosub_dp #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req         (i_req),
        .i_scroll_dist (r_scroll_dist),
        .o_stat        (stat),
        .o_valid       (o_result_valid),
        .o_result      (o_result)
    );

    // A request always ends with its last result as the block goes idle.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_result_valid && o_result.last))
        else $error("block went idle without a final result");

    // Only copy regions are emitted without last.
    a_copy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last) |-> (o_result.result_kind == KIND_COPY))
        else $error("non-final result is not a copy region");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // No result appears while idle except the one marking the end of a request.
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !busy && !$past(busy)) |-> !o_result_valid)
        else $error("result produced while idle");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the scroll region occlusion subtractor.
// ----------------------------------------------------------------------------
// Requests are sent one at a time through the start/busy handshake. Every
// accepted request is run through a behavioural model of the region list,
// and the results it predicts are queued. A checking process compares each
// strobed result field by field with the oldest queued expectation. The scroll
// distance is written over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import srosub_pkg::*;

    localparam int MAXR      = 16;
    localparam int CYC_LIMIT = 400000;

    // Rectangle held one bit wider than a coordinate, so ends never wrap.
    typedef struct {
        logic [16:0] x, y, w, h;
    } t_box;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_req                i_req;
    logic                o_result_valid;
    t_result             o_result;
    logic                psel, penable, pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    scroll_region_occlusion_subtractor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_result_valid(o_result_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow state of the block.
    t_box        regions [MAXR];
    int          n_regions;
    t_box        repaint;
    t_box        seed;
    logic [15:0] scroll_rows;

    t_result     pending_results [$];
    int          n_errors;
    int          n_checked;
    int          n_copies;
    int          n_overflows;
    int          cycles;
    int          n_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit, counted in clock cycles.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_box mk(logic [16:0] x, logic [16:0] y,
                                logic [16:0] w, logic [16:0] h);
        t_box b;
        b.x = x; b.y = y; b.w = w; b.h = h;
        return b;
    endfunction

    function automatic bit is_empty(t_box b);
        return b.w == 0 || b.h == 0;
    endfunction

    function automatic t_box overlap(t_box a, t_box b);
        logic [17:0] l, t, r, bt;
        if (is_empty(a) || is_empty(b)) return mk(0, 0, 0, 0);
        l  = (a.x > b.x) ? a.x : b.x;
        t  = (a.y > b.y) ? a.y : b.y;
        r  = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
        bt = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
        if (r <= l || bt <= t) return mk(0, 0, 0, 0);
        return mk(l, t, r - l, bt - t);
    endfunction

    function automatic t_box bound(t_box a, t_box b);
        logic [17:0] l, t, r, bt;
        if (is_empty(a)) return b;
        if (is_empty(b)) return a;
        l  = (a.x < b.x) ? a.x : b.x;
        t  = (a.y < b.y) ? a.y : b.y;
        r  = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
        bt = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
        return mk(l, t, r - l, bt - t);
    endfunction

    function automatic t_result make_result(logic [1:0] kind, t_box b, logic lst);
        t_result res;
        res.result_kind = kind;
        res.out_x       = b.x[15:0];
        res.out_y       = b.y[15:0];
        res.out_width   = b.w[15:0];
        res.out_height  = b.h[15:0];
        res.last        = lst;
        return res;
    endfunction

    // Removes the occluder from every region; returns 0 when the list
    // would overflow, leaving the list itself untouched in that case.
    function automatic bit carve_regions(t_box occ);
        t_box        next [MAXR];
        t_box        ov, r;
        t_box        pcs [4];
        int          nc, np;
        logic [17:0] rr, rb, orr, ob;
        nc = 0;
        for (int i = 0; i < n_regions; i++) begin
            r  = regions[i];
            ov = overlap(r, occ);
            repaint = bound(repaint, ov);
            np = 0;
            if (is_empty(ov)) begin
                pcs[np++] = r;
            end else begin
                rr  = r.x + r.w;
                rb  = r.y + r.h;
                orr = ov.x + ov.w;
                ob  = ov.y + ov.h;
                if (ov.y > r.y) pcs[np++] = mk(r.x, r.y, r.w, ov.y - r.y);
                if (ob < rb)    pcs[np++] = mk(r.x, ob, r.w, rb - ob);
                if (ov.x > r.x) pcs[np++] = mk(r.x, ov.y, ov.x - r.x, ov.h);
                if (orr < rr)   pcs[np++] = mk(orr, ov.y, rr - orr, ov.h);
            end
            for (int k = 0; k < np; k++) begin
                if (nc >= MAXR) return 1'b0;
                next[nc++] = pcs[k];
            end
        end
        for (int i = 0; i < nc; i++) regions[i] = next[i];
        n_regions = nc;
        return 1'b1;
    endfunction

    // Works out the results of one request and updates the shadow state.
    task automatic predict_regions(t_req rq);
        t_box        r, occ, z;
        logic [16:0] trim;
        z = mk(0, 0, 0, 0);
        r = mk(rq.rect_x, rq.rect_y, rq.rect_width, rq.rect_height);
        case (rq.req_type)
            REQ_START: begin
                // The seed is clipped to the coordinate space.
                if (r.x + r.w > 17'h10000) r.w = 17'h10000 - r.x;
                if (r.y + r.h > 17'h10000) r.h = 17'h10000 - r.y;
                if (is_empty(r)) r = z;
                seed      = r;
                repaint   = z;
                n_regions = 0;
                if (!is_empty(r)) begin
                    regions[0] = r;
                    n_regions  = 1;
                end
                pending_results.push_back(make_result(KIND_ACK, z, 1'b1));
            end
            REQ_SUB: begin
                // Shift the occluder up by the scroll distance, trimming at row zero.
                occ = z;
                if (!is_empty(r)) begin
                    if (r.y >= scroll_rows) begin
                        occ = mk(r.x, r.y - scroll_rows, r.w, r.h);
                    end else begin
                        trim = scroll_rows - r.y;
                        if (trim < r.h) occ = mk(r.x, 0, r.w, r.h - trim);
                    end
                end
                if (!is_empty(occ) && !carve_regions(occ)) begin
                    repaint   = bound(repaint, seed);
                    n_regions = 0;
                    n_overflows++;
                    pending_results.push_back(make_result(KIND_OVF, z, 1'b1));
                end else begin
                    pending_results.push_back(make_result(KIND_ACK, z, 1'b1));
                end
            end
            REQ_DRAIN: begin
                for (int i = 0; i < n_regions; i++) begin
                    if (regions[i].h <= scroll_rows) begin
                        repaint = bound(repaint, regions[i]);
                    end else begin
                        pending_results.push_back(make_result(KIND_COPY, regions[i], 1'b0));
                    end
                end
                pending_results.push_back(make_result(KIND_REPAINT,
                                          is_empty(repaint) ? z : repaint, 1'b1));
                n_regions = 0;
                repaint   = z;
            end
            default: begin
                pending_results.push_back(make_result(KIND_ACK, z, 1'b1));
            end
        endcase
    endtask

    // Every strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result %h with nothing pending.", o_result);
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (o_result.result_kind == KIND_COPY) n_copies++;
                if (o_result.result_kind !== exp_res.result_kind ||
                    o_result.out_x       !== exp_res.out_x ||
                    o_result.out_y       !== exp_res.out_y ||
                    o_result.out_width   !== exp_res.out_width ||
                    o_result.out_height  !== exp_res.out_height ||
                    o_result.last        !== exp_res.last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"Mismatch: expected k%0d %0d,%0d %0dx%0d l%0d,",
                                  " got k%0d %0d,%0d %0dx%0d l%0d"},
                                 exp_res.result_kind, exp_res.out_x, exp_res.out_y,
                                 exp_res.out_width, exp_res.out_height, exp_res.last,
                                 o_result.result_kind, o_result.out_x, o_result.out_y,
                                 o_result.out_width, o_result.out_height, o_result.last);
                end
            end
        end
    end

    bit calm;   // when set, the sender never idles

    // Sends one request and predicts its results once it is accepted.
    // start is dropped as soon as the request is accepted, so the next request is
    // always driven at a later edge than the one that lowers start.
    task automatic send_request(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                                logic [15:0] w, logic [15:0] h);
        t_req rq;
        rq.req_type    = kind;
        rq.rect_x      = x;
        rq.rect_y      = y;
        rq.rect_width  = w;
        rq.rect_height = h;
        while (!calm && $urandom_range(99) < 15) @(posedge i_clk);
        i_req <= rq;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_regions(rq);
        n_sent++;
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every result has arrived, then lets the block settle.
    task automatic wait_drained();
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes the scroll distance; the block must be idle.
    task automatic write_scroll(logic [15:0] rows);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(REG_SCROLL_DIST) << 2;
        pwdata  <= {16'h0, rows};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scroll_rows = rows;
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(5))
            0:       return 16'h0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(200));
        endcase
    endfunction

    // Directed checks: field extremes, every request code and each special case.
    task automatic test_directed();
        send_request(REQ_DRAIN, 0, 0, 0, 0);                     // empty repaint box
        send_request(REQ_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_DRAIN, 0, 0, 0, 0);
        send_request(REQ_START, 0, 0, 0, 16'h10);                // empty seed
        send_request(REQ_SUB, 0, 0, 16'h10, 16'h10);
        send_request(REQ_DRAIN, 0, 0, 0, 0);
        send_request(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // unknown code
        send_request(REQ_START, 10, 10, 100, 100);
        send_request(REQ_SUB, 40, 40, 0, 10);                    // empty occluder
        send_request(REQ_SUB, 40, 40, 20, 20);                   // hole in the middle
        send_request(REQ_SUB, 0, 0, 16'hFFFF, 5);
        send_request(REQ_DRAIN, 0, 0, 0, 0);
        write_scroll(16'd30);
        send_request(REQ_START, 0, 0, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SUB, 50, 10, 10, 15);                   // gone after the shift
        send_request(REQ_SUB, 50, 20, 10, 15);                   // trimmed at row zero
        send_request(REQ_SUB, 16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF);
        send_request(REQ_DRAIN, 0, 0, 0, 0);
        // A diagonal row of small holes pushes the list past its capacity.
        send_request(REQ_START, 0, 0, 1000, 1000);
        for (int i = 0; i < 6; i++)
            send_request(REQ_SUB, 100 + 120 * i, 100 + 120 * i + 30, 20, 20);
        send_request(REQ_DRAIN, 0, 0, 0, 0);
    endtask

    // Random sessions: start, several subtracts, drain, with some noise.
    task automatic test_random_sessions(int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                send_request(2'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            end else begin
                send_request(REQ_START, 16'($urandom_range(100)),
                             16'($urandom_range(100)),
                             16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)));
                repeat ($urandom_range(1, 6))
                    send_request(REQ_SUB, 16'($urandom_range(600)),
                                 16'($urandom_range(650)),
                                 rnd_coord(), rnd_coord());
                send_request(REQ_DRAIN, 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Several scroll distances, the extremes among them.
    task automatic test_scroll_settings();
        write_scroll(16'd0);
        test_random_sessions(80);
        write_scroll(16'hFFFF);
        test_random_sessions(30);
        write_scroll(16'($urandom_range(1, 60)));
        calm = 1'b1;                                             // no idling here
        test_random_sessions(70);
        calm = 1'b0;
        write_scroll(16'($urandom_range(1, 300)));
        test_random_sessions(80);
        wait_drained();                                          // sender holds off
        write_scroll(16'($urandom));
        test_random_sessions(50);
    endtask

    initial begin
        n_errors = 0; n_checked = 0; n_copies = 0; n_overflows = 0;
        cycles = 0; n_sent = 0; calm = 1'b0;
        n_regions = 0; scroll_rows = '0;
        repaint = mk(0, 0, 0, 0);
        seed    = mk(0, 0, 0, 0);
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_scroll_settings();
        wait_drained();

        $display("Sent %0d requests and checked %0d results,", n_sent, n_checked);
        $display("including %0d copy regions and %0d list overflows.", n_copies, n_overflows);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total.", n_errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
